FILE: design/d4_reconciliation_hint_gen_defines.svh
// Assertion macros for the D4 reconciliation hint generator
`ifndef D4_RECONCILIATION_HINT_GEN_DEFINES_SVH
`define D4_RECONCILIATION_HINT_GEN_DEFINES_SVH

// same-cycle implication on clk, quiet during reset
`define D4RHG_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("d4 hint gen: same-cycle check failed");

// next-cycle implication on clk, quiet during reset
`define D4RHG_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("d4 hint gen: next-cycle check failed");

`endif

FILE: design/d4rhg_pkg.sv
// Package: widths, constants, helper functions and types of the D4 hint generator
`timescale 1ns / 1ps
package d4rhg_pkg;

	localparam int MODULUS   = 12289;
	localparam int COEFF_W   = 14;
	localparam int X_W       = 17;
	localparam int T_W       = 4;
	localparam int T_MAX     = 10;
	localparam int PT_W      = 3;
	localparam int DIST_W    = 14;
	localparam int SUM_W     = 16;
	localparam int HINT_W    = 2;
	localparam int LANES     = 4;

	localparam logic [SUM_W-1:0] SEL_LIMIT = SUM_W'(2 * MODULUS);

	// load enables for the two lane stages
	typedef struct packed {
		logic s1;
		logic s2;
	} d4rhg_adv_t;

	// floor(x / MODULUS) for x below 11 * MODULUS, by threshold compares
	function automatic logic [T_W-1:0] quot_of(input logic [X_W-1:0] x);
		logic [T_W-1:0] t;
		t = '0;
		for (int k = 1; k <= T_MAX; k++) begin
			if (x >= X_W'(k * MODULUS))
				t = T_W'(k);
		end
		return t;
	endfunction

	// lattice point times 2*MODULUS, point at most 5
	function automatic logic [X_W-1:0] base_of(input logic [PT_W-1:0] r);
		logic [X_W-1:0] b;
		case (r)
			3'd0:    b = X_W'(0);
			3'd1:    b = X_W'(2 * MODULUS);
			3'd2:    b = X_W'(4 * MODULUS);
			3'd3:    b = X_W'(6 * MODULUS);
			3'd4:    b = X_W'(8 * MODULUS);
			3'd5:    b = X_W'(10 * MODULUS);
			default: b = X_W'(10 * MODULUS);
		endcase
		return b;
	endfunction

endpackage

FILE: design/d4rhg_if.sv
// Handshake interfaces for the coefficient group and the hint result
`timescale 1ns / 1ps
interface d4rhg_in_if;
	import d4rhg_pkg::*;
	logic               valid;
	logic               ready;
	logic [COEFF_W-1:0] coeff_a;
	logic [COEFF_W-1:0] coeff_b;
	logic [COEFF_W-1:0] coeff_c;
	logic [COEFF_W-1:0] coeff_d;
	logic               dither_bit;

	modport source (output valid, coeff_a, coeff_b, coeff_c, coeff_d, dither_bit,
		input ready);
	modport sink (input valid, coeff_a, coeff_b, coeff_c, coeff_d, dither_bit,
		output ready);
endinterface

interface d4rhg_out_if;
	import d4rhg_pkg::*;
	logic              valid;
	logic              ready;
	logic [HINT_W-1:0] hint_a;
	logic [HINT_W-1:0] hint_b;
	logic [HINT_W-1:0] hint_c;
	logic [HINT_W-1:0] hint_d;

	modport source (output valid, hint_a, hint_b, hint_c, hint_d, input ready);
	modport sink (input valid, hint_a, hint_b, hint_c, hint_d, output ready);
endinterface

FILE: design/d4rhg_lane.sv
// One coefficient lane: scale, quotient, candidate points and distance
`timescale 1ns / 1ps
module d4rhg_lane
	import d4rhg_pkg::*;
(
	input  logic               clk,
	input  d4rhg_adv_t         adv,
	input  logic [COEFF_W-1:0] coeff,
	input  logic               dither_bit,
	output logic [DIST_W-1:0]  distance,
	output logic [PT_W-1:0]    p_round,
	output logic [PT_W-1:0]    p_shift
);

	logic [X_W-1:0]    x_s1;
	logic [T_W-1:0]    t_s1;
	logic [X_W-1:0]    x_d;
	logic [PT_W-1:0]   r_d;
	logic [X_W-1:0]    base_d;
	logic [X_W-1:0]    dist_d;
	logic [DIST_W-1:0] dist_s2;
	logic [PT_W-1:0]   p0_s2;
	logic [PT_W-1:0]   p1_s2;

	// 8*v + 4*dither is a plain concatenation
	assign x_d = {coeff, dither_bit, 2'b00};

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			x_s1 <= x_d;
			t_s1 <= quot_of(x_d);
		end
	end

	assign r_d    = PT_W'(t_s1[T_W-1:1]) + PT_W'(t_s1[0]);
	assign base_d = base_of(r_d);
	assign dist_d = (x_s1 >= base_d) ? (x_s1 - base_d) : (base_d - x_s1);

	// distance never exceeds MODULUS, so it fits the narrow register
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			dist_s2 <= dist_d[DIST_W-1:0];
			p0_s2   <= r_d;
			p1_s2   <= PT_W'(t_s1[T_W-1:1]);
		end
	end

	assign distance = dist_s2;
	assign p_round  = p0_s2;
	assign p_shift  = p1_s2;

endmodule

FILE: design/d4_reconciliation_hint_gen.sv
// D4 reconciliation hint generator: lanes, distance sum, point select and hints
// Usage:
//   coeffs (sink): one group of four coefficients and a dither bit per request,
//     taken at a clock edge with valid and ready both high.
//   hints (source): four 2-bit hints per group, in input order, valid/ready.
// Pipeline: four register stages (scale and quotient, distance, distance sum,
//   select and hints into the output register). The first stage loads at the
//   accepting edge and valid on hints rises once the group reaches the output
//   register; one group a cycle is sustained while the receiver keeps ready high.
// Each stage has its own valid bit and loads whenever it is empty or the stage
//   after it moves, so bubbles close up while the receiver stalls and ready on
//   coeffs drops only once all four stages hold a group. A stalled result holds
//   in the output register unchanged.
// Reset (arst_n low, asynchronous) empties all stages; no result is pending
//   afterwards and the block takes a request as soon as reset is released.
`timescale 1ns / 1ps
`include "d4_reconciliation_hint_gen_defines.svh"
module d4_reconciliation_hint_gen
	import d4rhg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	d4rhg_in_if.sink    coeffs,
	d4rhg_out_if.source hints
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	d4rhg_adv_t adv;

	logic [COEFF_W-1:0] coeff_in [LANES];
	logic [DIST_W-1:0]  dist_l   [LANES];
	logic [PT_W-1:0]    p0_l     [LANES];
	logic [PT_W-1:0]    p1_l     [LANES];

	logic [SUM_W-1:0]  sum_s3;
	logic [PT_W-1:0]   p0_s3 [LANES];
	logic [PT_W-1:0]   p1_s3 [LANES];
	logic              sel_d;
	logic [PT_W-1:0]   pt_d  [LANES];
	logic [HINT_W-1:0] hint_a_s4, hint_b_s4, hint_c_s4, hint_d_s4;

	// a stage loads when empty or when its content moves on
	assign rdy_s4 = !v_s4 || hints.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign coeffs.ready = rdy_s1;
	assign adv.s1 = rdy_s1;
	assign adv.s2 = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= coeffs.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign coeff_in[0] = coeffs.coeff_a;
	assign coeff_in[1] = coeffs.coeff_b;
	assign coeff_in[2] = coeffs.coeff_c;
	assign coeff_in[3] = coeffs.coeff_d;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		d4rhg_lane u_lane (
			.clk        (clk),
			.adv        (adv),
			.coeff      (coeff_in[i]),
			.dither_bit (coeffs.dither_bit),
			.distance   (dist_l[i]),
			.p_round    (p0_l[i]),
			.p_shift    (p1_l[i])
		);
	end

	// sum of four distances, at most 4*MODULUS
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sum_s3 <= (SUM_W'(dist_l[0]) + SUM_W'(dist_l[1]))
				+ (SUM_W'(dist_l[2]) + SUM_W'(dist_l[3]));
			for (int i = 0; i < LANES; i++) begin
				p0_s3[i] <= p0_l[i];
				p1_s3[i] <= p1_l[i];
			end
		end
	end

	assign sel_d = (sum_s3 >= SEL_LIMIT);

	always_comb begin
		for (int i = 0; i < LANES; i++)
			pt_d[i] = sel_d ? p1_s3[i] : p0_s3[i];
	end

	// only the low two bits of each point matter mod 4
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			hint_a_s4 <= pt_d[0][HINT_W-1:0] - pt_d[3][HINT_W-1:0];
			hint_b_s4 <= pt_d[1][HINT_W-1:0] - pt_d[3][HINT_W-1:0];
			hint_c_s4 <= pt_d[2][HINT_W-1:0] - pt_d[3][HINT_W-1:0];
			hint_d_s4 <= {pt_d[3][0], sel_d};
		end
	end

	assign hints.valid  = v_s4;
	assign hints.hint_a = hint_a_s4;
	assign hints.hint_b = hint_b_s4;
	assign hints.hint_c = hint_c_s4;
	assign hints.hint_d = hint_d_s4;

	`D4RHG_ASSERT_NOW(a_dist_bound, v_s2, (dist_l[0] <= DIST_W'(MODULUS)) && (dist_l[1] <= DIST_W'(MODULUS)) && (dist_l[2] <= DIST_W'(MODULUS)) && (dist_l[3] <= DIST_W'(MODULUS)))
	`D4RHG_ASSERT_NEXT(a_sum_hold, v_s3 && !rdy_s4, v_s3 && $stable(sum_s3))
	`D4RHG_ASSERT_NEXT(a_sel_flag, v_s3 && rdy_s4, v_s4 && (hints.hint_d[0] == $past(sel_d)))

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the D4 reconciliation hint generator: random and edge groups
`timescale 1ns / 1ps
module tb;
	import d4rhg_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RANDOM_COUNT = 1300;
	localparam int LONG_HOLD_AT = 350;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 12;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [COEFF_W-1:0] coeff [LANES];
		logic               dither;
		int unsigned        gap;
		bit                 wait_drained;
	} coeff_group_t;

	typedef struct packed {
		logic [HINT_W-1:0] a;
		logic [HINT_W-1:0] b;
		logic [HINT_W-1:0] c;
		logic [HINT_W-1:0] d;
	} hint_set_t;

	logic clk;
	logic arst_n;

	d4rhg_in_if  coeffs_if ();
	d4rhg_out_if hints_if ();

	d4_reconciliation_hint_gen u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.coeffs (coeffs_if),
		.hints  (hints_if)
	);

	coeff_group_t pending_groups [$];
	hint_set_t    hints_expected [$];
	coeff_group_t tx_cur;
	int unsigned  tx_gap_left;
	int unsigned  rx_stall_left;
	int unsigned  results_seen;
	int unsigned  fail_count;
	int unsigned  cycle_count;
	int unsigned  rx_stall;
	hint_set_t    rx_got;
	hint_set_t    rx_want;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// nearest and shifted D4 points of the four lanes, then the hint set
	function automatic hint_set_t hint_predict(input coeff_group_t g);
		int unsigned x, t, near_pt, lane_dist, dist_sum;
		int          chosen [LANES];
		int          near_pts [LANES];
		int          shift_pts [LANES];
		bit          use_shift;
		hint_set_t   h;
		dist_sum = 0;
		for (int i = 0; i < LANES; i++) begin
			x            = 8 * int'(g.coeff[i]) + 4 * int'(g.dither);
			t            = x / MODULUS;
			near_pt      = (t + 1) / 2;
			near_pts[i]  = near_pt;
			shift_pts[i] = t / 2;
			lane_dist    = (x >= near_pt * 2 * MODULUS) ? x - near_pt * 2 * MODULUS
				: near_pt * 2 * MODULUS - x;
			dist_sum += lane_dist;
		end
		use_shift = (dist_sum >= 2 * MODULUS);
		for (int i = 0; i < LANES; i++)
			chosen[i] = use_shift ? shift_pts[i] : near_pts[i];
		h.a = HINT_W'(chosen[0] - chosen[3]);
		h.b = HINT_W'(chosen[1] - chosen[3]);
		h.c = HINT_W'(chosen[2] - chosen[3]);
		h.d = HINT_W'(int'(use_shift) + 2 * chosen[3]);
		return h;
	endfunction

	// mostly short waits, now and then a long one
	function automatic int unsigned draw_wait();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
	endfunction

	function automatic logic [COEFF_W-1:0] pick_coeff();
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 2**COEFF_W - 1);
			1, 2: begin
				// land close to a quotient step, where rounding flips
				v = ($urandom_range(0, 10) * MODULUS) / 8 + $urandom_range(0, 4) - 2;
				if (v < 0)
					v = 0;
			end
			default: v = $urandom_range(0, MODULUS - 1);
		endcase
		return COEFF_W'(v);
	endfunction

	task automatic add_group(input int unsigned a, b, c, d, input bit dither,
		input int unsigned gap, input bit wait_drained);
		coeff_group_t g;
		g.coeff[0]     = COEFF_W'(a);
		g.coeff[1]     = COEFF_W'(b);
		g.coeff[2]     = COEFF_W'(c);
		g.coeff[3]     = COEFF_W'(d);
		g.dither       = dither;
		g.gap          = gap;
		g.wait_drained = wait_drained;
		pending_groups.push_back(g);
	endtask

	task automatic report(input string field, input logic [HINT_W-1:0] got,
		input logic [HINT_W-1:0] want);
		$display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
			$realtime, results_seen, field, got, want);
		fail_count++;
	endtask

	// driver: present the head of the queue, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_if.valid <= 1'b0;
			tx_gap_left     <= 0;
		end else begin
			if (coeffs_if.valid && coeffs_if.ready)
				hints_expected.push_back(hint_predict(tx_cur));
			if (!(coeffs_if.valid && !coeffs_if.ready)) begin
				if (tx_gap_left != 0) begin
					coeffs_if.valid <= 1'b0;
					tx_gap_left     <= tx_gap_left - 1;
				end else if (pending_groups.size() != 0 &&
					!(pending_groups[0].wait_drained && hints_expected.size() != 0)) begin
					tx_cur = pending_groups.pop_front();
					coeffs_if.coeff_a    <= tx_cur.coeff[0];
					coeffs_if.coeff_b    <= tx_cur.coeff[1];
					coeffs_if.coeff_c    <= tx_cur.coeff[2];
					coeffs_if.coeff_d    <= tx_cur.coeff[3];
					coeffs_if.dither_bit <= tx_cur.dither;
					coeffs_if.valid      <= 1'b1;
					tx_gap_left          <= tx_cur.gap;
				end else begin
					coeffs_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: take hints, check against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hints_if.ready <= 1'b0;
			rx_stall_left  <= 0;
		end else if (hints_if.valid && hints_if.ready) begin
			rx_got = '{a: hints_if.hint_a, b: hints_if.hint_b, c: hints_if.hint_c,
				d: hints_if.hint_d};
			if (hints_expected.size() == 0) begin
				$display("[%0t] hint set with no request outstanding", $realtime);
				fail_count++;
			end else begin
				rx_want = hints_expected.pop_front();
				if (rx_got.a !== rx_want.a) report("hint_a", rx_got.a, rx_want.a);
				if (rx_got.b !== rx_want.b) report("hint_b", rx_got.b, rx_want.b);
				if (rx_got.c !== rx_want.c) report("hint_c", rx_got.c, rx_want.c);
				if (rx_got.d !== rx_want.d) report("hint_d", rx_got.d, rx_want.d);
			end
			results_seen++;
			// hold off long enough for the pipe to fill and back up the input
			if (results_seen == LONG_HOLD_AT)
				rx_stall = LONG_HOLD;
			else if (results_seen >= 100 && results_seen < 250)
				rx_stall = 0;
			else
				rx_stall = draw_wait();
			if (rx_stall == 0) begin
				hints_if.ready <= 1'b1;
			end else begin
				hints_if.ready <= 1'b0;
				rx_stall_left  <= rx_stall - 1;
			end
		end else if (rx_stall_left != 0) begin
			hints_if.ready <= 1'b0;
			rx_stall_left  <= rx_stall_left - 1;
		end else begin
			hints_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[%0t] run timed out", $realtime);
			$display("** d4_reconciliation_hint_gen: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		arst_n               = 1'b0;
		coeffs_if.valid      = 1'b0;
		coeffs_if.coeff_a    = '0;
		coeffs_if.coeff_b    = '0;
		coeffs_if.coeff_c    = '0;
		coeffs_if.coeff_d    = '0;
		coeffs_if.dither_bit = 1'b0;
		hints_if.ready       = 1'b0;
		fail_count           = 0;
		results_seen         = 0;
		cycle_count          = 0;

		// edges of the range, quotient steps and the select boundary
		add_group(0, 0, 0, 0, 0, draw_wait(), 0);
		add_group(0, 0, 0, 0, 1, draw_wait(), 0);
		add_group(MODULUS - 1, MODULUS - 1, MODULUS - 1, MODULUS - 1, 0, draw_wait(), 0);
		add_group(MODULUS - 1, MODULUS - 1, MODULUS - 1, MODULUS - 1, 1, draw_wait(), 0);
		add_group(16383, 16383, 16383, 16383, 0, draw_wait(), 0);
		add_group(16383, 16383, 16383, 16383, 1, draw_wait(), 0);
		add_group(MODULUS, 12800, 14000, 16383, 1, draw_wait(), 0);
		add_group(1536, 1536, 1536, 1536, 0, draw_wait(), 0);
		add_group(1536, 1536, 1536, 1536, 1, draw_wait(), 0);
		add_group(1537, 1537, 1537, 1537, 0, draw_wait(), 0);
		add_group(768, 768, 768, 768, 0, draw_wait(), 0);
		add_group(768, 768, 768, 768, 1, draw_wait(), 0);
		add_group(3072, 3072, 3072, 3072, 0, draw_wait(), 0);
		add_group(4608, 7680, 10752, 1536, 1, draw_wait(), 0);
		add_group(0, 16383, 0, 16383, 0, draw_wait(), 0);
		add_group(16383, 0, 8192, 4096, 1, draw_wait(), 0);
		add_group(10752, 10753, 10751, 9216, 0, draw_wait(), 0);
		add_group(1536, 0, 0, 0, 1, draw_wait(), 0);
		add_group(0, 0, 0, 1536, 1, draw_wait(), 0);
		add_group(6144, 6145, 6143, 6144, 0, draw_wait(), 0);
		add_group(5461, 10922, 2730, 8191, 1, draw_wait(), 0);
		add_group(12288, 0, 12288, 0, 0, draw_wait(), 1);

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			// keep offering back to back while the receiver holds off
			gap = ((i >= 300 && i < 650) || (i >= 900 && i < 1000)) ? 0 : draw_wait();
			add_group(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
				$urandom_range(0, 1), gap, i == 700 || i == 1100);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_groups.size() != 0 || coeffs_if.valid)
			@(posedge clk);
		while (hints_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("** d4_reconciliation_hint_gen: PASSED **");
		else
			$display("** d4_reconciliation_hint_gen: FAILED **");
		$finish;
	end

endmodule
